### sv/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg: shared definitions for the modulated polar curve generator
// Formats, fixed constants, register indexes, datapath opcodes and the
// controller state type.
// ----------------------------------------------------------------------------
package spcp_pkg;

  localparam int ANGLE_FRAC_BITS = 20;
  localparam int ANGLE_W         = ANGLE_FRAC_BITS + 3;
  localparam int ANGLE_SHIFT     = 30 - ANGLE_FRAC_BITS;
  localparam int STEP_W          = 21;
  localparam int COUNT_W         = 20;
  localparam int LEN_W           = 32;
  localparam int LOBES_W         = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam int CORDIC_ITERATIONS_DEF = 20;

  // internal widths
  localparam int Q_W     = ANGLE_W + ANGLE_SHIFT;  // unsigned Q30 angle
  localparam int Z_W     = Q_W + 1;                // signed residual angle
  localparam int XY_W    = 33;                     // signed Q30 vector
  localparam int R_W     = 34;                     // signed Q16.16 radius, wide
  localparam int PROD_W  = R_W + XY_W;
  localparam int RND_W   = PROD_W - 30;
  localparam int PHASE_W = Z_W + LOBES_W;          // lobes * theta, signed
  localparam int MAG_W   = PHASE_W - 1;
  localparam int RED_K_W = 3;
  localparam logic [RED_K_W-1:0] RED_K_TOP = RED_K_W'(LOBES_W - 2);

  localparam logic [Q_W-1:0] TWO_PI_Q30        = 33'd6746518852;
  localparam logic [Q_W-1:0] PI_Q30            = 33'd3373259426;
  localparam logic [Q_W-1:0] HALF_PI_Q30       = 33'd1686629713;
  localparam logic [Q_W-1:0] THREE_HALF_PI_Q30 = PI_Q30 + HALF_PI_Q30;
  localparam logic [XY_W-1:0] GAIN_Q30         = 33'd652032874;

  localparam logic [ANGLE_W-1:0] TWO_PI_FMT =
    ANGLE_W'((64'd6746518852 + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT);

  localparam logic [STEP_W-1:0]  STEP_RESET  = 21'd1048;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 20'd6283;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_AMPLITUDE,
    REG_LOBES,
    REG_CENTRE_X,
    REG_CENTRE_Y,
    REG_ANGLE_STEP,
    REG_POINT_COUNT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_THETA,
    OP_MUL_PHASE,
    OP_RED_PHASE,
    OP_FOLD_A,
    OP_CORDIC,
    OP_FOLD_B,
    OP_MUL_AMP,
    OP_ADD_R,
    OP_MUL_X,
    OP_ADD_X,
    OP_ADD_Y,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic red_done;
    logic cordic_done;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_THETA,
    S_MUL_PHASE,
    S_RED_PHASE,
    S_FOLD_A,
    S_CORDIC_A,
    S_FOLD_B,
    S_CORDIC_B,
    S_MUL_AMP,
    S_ADD_R,
    S_MUL_X,
    S_ADD_X,
    S_ADD_Y,
    S_OUT
  } ctrl_state_t;

  // arctangent of 2^-i in Q30
  function automatic logic [30:0] atan_q30(input int i);
    case (i)
      0:       atan_q30 = 31'd843314856;
      1:       atan_q30 = 31'd497837829;
      2:       atan_q30 = 31'd263043836;
      3:       atan_q30 = 31'd133525158;
      4:       atan_q30 = 31'd67021686;
      5:       atan_q30 = 31'd33543515;
      6:       atan_q30 = 31'd16775850;
      7:       atan_q30 = 31'd8388437;
      8:       atan_q30 = 31'd4194282;
      9:       atan_q30 = 31'd2097149;
      default: atan_q30 = 31'(1) << (30 - i);
    endcase
  endfunction

endpackage

### sv/spcp_if.sv
// ----------------------------------------------------------------------------
// spcp_if: request and result channels
// Valid/ready channels carrying one request item and one point.
// ----------------------------------------------------------------------------
interface spcp_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [spcp_pkg::ANGLE_W-1:0] angle;

  modport source(output valid, func, angle, input ready);
  modport sink(input valid, func, angle, output ready);
endinterface

interface spcp_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [spcp_pkg::LEN_W-1:0] x;
  logic signed [spcp_pkg::LEN_W-1:0] y;
  logic                              last;

  modport source(output valid, x, y, last, input ready);
  modport sink(input valid, x, y, last, output ready);
endinterface

### sv/spcp_ctrl.sv
// ----------------------------------------------------------------------------
// spcp_ctrl: sequencer for the polar curve datapath
// Walks one request through angle reduction, two CORDIC passes, the radius
// and coordinate products, and hands the point to the output register.
// ----------------------------------------------------------------------------
module spcp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  spcp_pkg::dp_status_t status,
  output spcp_pkg::dp_op_t     op
);
  import spcp_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (req_valid) state_next = S_RED_THETA;
      S_RED_THETA: state_next = S_MUL_PHASE;
      S_MUL_PHASE: state_next = S_RED_PHASE;
      S_RED_PHASE: if (status.red_done) state_next = S_FOLD_A;
      S_FOLD_A:    state_next = S_CORDIC_A;
      S_CORDIC_A:  if (status.cordic_done) state_next = S_FOLD_B;
      S_FOLD_B:    state_next = S_CORDIC_B;
      S_CORDIC_B:  if (status.cordic_done) state_next = S_MUL_AMP;
      S_MUL_AMP:   state_next = S_ADD_R;
      S_ADD_R:     state_next = S_MUL_X;
      S_MUL_X:     state_next = S_ADD_X;
      S_ADD_X:     state_next = S_ADD_Y;
      S_ADD_Y:     state_next = S_OUT;
      S_OUT:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    case (state)
      S_IDLE:      if (req_valid) op = OP_LOAD;
      S_RED_THETA: op = OP_RED_THETA;
      S_MUL_PHASE: op = OP_MUL_PHASE;
      S_RED_PHASE: op = OP_RED_PHASE;
      S_FOLD_A:    op = OP_FOLD_A;
      S_CORDIC_A:  op = OP_CORDIC;
      S_FOLD_B:    op = OP_FOLD_B;
      S_CORDIC_B:  op = OP_CORDIC;
      S_MUL_AMP:   op = OP_MUL_AMP;
      S_ADD_R:     op = OP_ADD_R;
      S_MUL_X:     op = OP_MUL_X;
      S_ADD_X:     op = OP_ADD_X;
      S_ADD_Y:     op = OP_ADD_Y;
      S_OUT:       if (out_free) op = OP_OUT;
      default:     op = OP_NONE;
    endcase
  end

endmodule

### sv/spcp_datapath.sv
// ----------------------------------------------------------------------------
// spcp_datapath: registers, sweep state, angle reduction, CORDIC and products
// One shared rotation-mode CORDIC, one modulo-two-pi reducer and one wide
// multiplier, each stepped by the controller opcode.
// ----------------------------------------------------------------------------
module spcp_datapath #(
  parameter int CORDIC_ITERATIONS = spcp_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [spcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_func,
  input  logic [spcp_pkg::ANGLE_W-1:0]        req_angle,
  input  spcp_pkg::dp_op_t                    op,
  output spcp_pkg::dp_status_t                status,
  output logic signed [spcp_pkg::LEN_W-1:0]   rsp_x,
  output logic signed [spcp_pkg::LEN_W-1:0]   rsp_y,
  output logic                                rsp_last
);
  import spcp_pkg::*;

  localparam int IT_W = $clog2(CORDIC_ITERATIONS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_ITERATIONS - 1);
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(64'd536870912);

  // configuration
  logic signed [LEN_W-1:0]   radius;
  logic signed [LEN_W-1:0]   amplitude;
  logic signed [LOBES_W-1:0] lobes;
  logic signed [LEN_W-1:0]   centre_x;
  logic signed [LEN_W-1:0]   centre_y;
  logic [STEP_W-1:0]         angle_step;
  logic [COUNT_W-1:0]        point_count;

  // sweep
  logic [COUNT_W-1:0] sweep_index;
  logic [ANGLE_W-1:0] sweep_angle;
  logic               last_flag;

  // reduction
  logic [Q_W-1:0]     theta;
  logic [MAG_W-1:0]   red_m;
  logic [RED_K_W-1:0] red_k;
  logic               red_neg;

  // cordic
  logic signed [XY_W-1:0] cordic_x;
  logic signed [XY_W-1:0] cordic_y;
  logic signed [Z_W-1:0]  cordic_z;
  logic                   flip;
  logic [IT_W-1:0]        iter;
  logic signed [XY_W-1:0] s2;

  // products
  logic signed [R_W-1:0]    r;
  logic signed [PROD_W-1:0] prod;
  logic [LEN_W-1:0]         xres;
  logic [LEN_W-1:0]         yres;

  // combinational
  logic [COUNT_W:0]         sweep_inc;
  logic                     sweep_end;
  logic [ANGLE_W:0]         angle_sum;
  logic [ANGLE_W:0]         angle_wrap;
  logic [ANGLE_W-1:0]       theta_sel;
  logic [MAG_W-1:0]         red_sub;
  logic [MAG_W:0]           red_diff;
  logic [MAG_W-1:0]         red_step;
  logic signed [PHASE_W-1:0] phase_prod;
  logic [PHASE_W-1:0]       phase_abs;
  logic [Q_W-1:0]           phase;
  logic [Z_W:0]             fold_a;
  logic [Z_W:0]             fold_b;
  logic signed [XY_W-1:0]   dx;
  logic signed [XY_W-1:0]   dy;
  logic signed [Z_W-1:0]    atan_z;
  logic signed [XY_W-1:0]   cos_v;
  logic signed [XY_W-1:0]   sin_v;
  logic signed [R_W-1:0]    mul_a;
  logic signed [XY_W-1:0]   mul_b;
  logic [PROD_W-1:0]        prod_sum;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  r_sum;
  logic signed [RND_W:0]    sum_x;
  logic signed [RND_W:0]    sum_y;

  // {flip, z}: angle in [0, 2pi) folded into [-pi/2, pi/2]
  function automatic logic [Z_W:0] fold(input logic [Q_W-1:0] a);
    logic [Z_W-1:0] az;
    az = {1'b0, a};
    if (a > HALF_PI_Q30 && a < THREE_HALF_PI_Q30) begin
      fold = {1'b1, az - Z_W'(PI_Q30)};
    end else if (a >= THREE_HALF_PI_Q30) begin
      fold = {1'b0, az - Z_W'(TWO_PI_Q30)};
    end else begin
      fold = {1'b0, az};
    end
  endfunction

  function automatic logic [LEN_W-1:0] sat(input logic signed [RND_W:0] v);
    if (v[RND_W:LEN_W-1] == {(RND_W - LEN_W + 2){1'b0}} ||
        v[RND_W:LEN_W-1] == {(RND_W - LEN_W + 2){1'b1}}) begin
      sat = v[LEN_W-1:0];
    end else if (v[RND_W]) begin
      sat = {1'b1, {(LEN_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(LEN_W - 1){1'b1}}};
    end
  endfunction

  // sweep bookkeeping
  assign sweep_inc  = {1'b0, sweep_index} + (COUNT_W + 1)'(1);
  assign sweep_end  = sweep_inc >= {1'b0, point_count};
  assign angle_sum  = {1'b0, sweep_angle} + (ANGLE_W + 1)'(angle_step);
  assign angle_wrap = (angle_sum >= {1'b0, TWO_PI_FMT}) ?
                      angle_sum - {1'b0, TWO_PI_FMT} : angle_sum;
  assign theta_sel  = req_func ? sweep_angle : req_angle;

  // modulo two pi, one conditional subtract of 2pi << k per cycle
  assign red_sub  = {{(MAG_W - Q_W){1'b0}}, TWO_PI_Q30} << red_k;
  assign red_diff = {1'b0, red_m} - {1'b0, red_sub};
  assign red_step = red_diff[MAG_W] ? red_m : red_diff[MAG_W-1:0];

  assign phase_prod = lobes * $signed({1'b0, theta});
  assign phase_abs  = phase_prod[PHASE_W-1] ? -phase_prod : phase_prod;
  assign phase      = (red_neg && red_m != '0) ?
                      TWO_PI_Q30 - red_m[Q_W-1:0] : red_m[Q_W-1:0];
  assign fold_a     = fold(phase);
  assign fold_b     = fold(theta);

  // cordic micro-rotation
  assign dx     = cordic_y >>> iter;
  assign dy     = cordic_x >>> iter;
  assign atan_z = Z_W'(atan_q30(int'(iter)));
  assign cos_v  = flip ? -cordic_x : cordic_x;
  assign sin_v  = flip ? -cordic_y : cordic_y;

  assign status.red_done    = (red_k == '0);
  assign status.cordic_done = (iter == IT_LAST);

  // shared multiplier operands
  always_comb begin
    mul_a = r;
    mul_b = sin_v;
    case (op)
      OP_MUL_AMP: begin
        mul_a = R_W'(amplitude);
        mul_b = s2;
      end
      OP_MUL_X: mul_b = cos_v;
      default:  mul_b = sin_v;
    endcase
  end

  assign prod_sum = prod + RND_HALF;
  assign rnd      = $signed(prod_sum[PROD_W-1:30]);
  assign r_sum    = rnd + RND_W'(radius);
  assign sum_x    = (RND_W + 1)'(rnd) + (RND_W + 1)'(centre_x);
  assign sum_y    = (RND_W + 1)'(rnd) + (RND_W + 1)'(centre_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= '0;
      amplitude   <= '0;
      lobes       <= '0;
      centre_x    <= '0;
      centre_y    <= '0;
      angle_step  <= STEP_RESET;
      point_count <= COUNT_RESET;
      sweep_index <= '0;
      sweep_angle <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_RADIUS:      radius      <= cfg_data[LEN_W-1:0];
          REG_AMPLITUDE:   amplitude   <= cfg_data[LEN_W-1:0];
          REG_LOBES:       lobes       <= cfg_data[LOBES_W-1:0];
          REG_CENTRE_X:    centre_x    <= cfg_data[LEN_W-1:0];
          REG_CENTRE_Y:    centre_y    <= cfg_data[LEN_W-1:0];
          REG_ANGLE_STEP:  angle_step  <= cfg_data[STEP_W-1:0];
          REG_POINT_COUNT: point_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (op == OP_LOAD && req_func) begin
        if (sweep_end) begin
          sweep_index <= '0;
          sweep_angle <= '0;
        end else begin
          sweep_index <= sweep_inc[COUNT_W-1:0];
          sweep_angle <= angle_wrap[ANGLE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        last_flag <= req_func && sweep_end;
        red_m     <= {{(MAG_W - Q_W){1'b0}}, theta_sel, {ANGLE_SHIFT{1'b0}}};
        red_k     <= '0;
      end
      OP_RED_THETA: theta <= red_step[Q_W-1:0];
      OP_MUL_PHASE: begin
        red_m   <= phase_abs[MAG_W-1:0];
        red_neg <= phase_prod[PHASE_W-1];
        red_k   <= RED_K_TOP;
      end
      OP_RED_PHASE: begin
        red_m <= red_step;
        red_k <= red_k - RED_K_W'(1);
      end
      OP_FOLD_A: begin
        flip     <= fold_a[Z_W];
        cordic_z <= fold_a[Z_W-1:0];
        cordic_x <= GAIN_Q30;
        cordic_y <= '0;
        iter     <= '0;
      end
      OP_CORDIC: begin
        if (!cordic_z[Z_W-1]) begin
          cordic_x <= cordic_x - dx;
          cordic_y <= cordic_y + dy;
          cordic_z <= cordic_z - atan_z;
        end else begin
          cordic_x <= cordic_x + dx;
          cordic_y <= cordic_y - dy;
          cordic_z <= cordic_z + atan_z;
        end
        iter <= iter + IT_W'(1);
      end
      OP_FOLD_B: begin
        s2       <= sin_v;
        flip     <= fold_b[Z_W];
        cordic_z <= fold_b[Z_W-1:0];
        cordic_x <= GAIN_Q30;
        cordic_y <= '0;
        iter     <= '0;
      end
      OP_MUL_AMP: prod <= mul_a * mul_b;
      OP_ADD_R:   r <= r_sum[R_W-1:0];
      OP_MUL_X:   prod <= mul_a * mul_b;
      OP_ADD_X: begin
        xres <= sat(sum_x);
        prod <= mul_a * mul_b;
      end
      OP_ADD_Y: yres <= sat(sum_y);
      OP_OUT: begin
        rsp_x    <= xres;
        rsp_y    <= yres;
        rsp_last <= last_flag;
      end
      default: ;
    endcase
  end

endmodule

### sv/sinusoidal_polar_curve_points.sv
// ----------------------------------------------------------------------------
// sinusoidal_polar_curve_points: points on a sinusoidally modulated circle
// r = radius + amplitude*sin(lobes*theta); x = r*cos(theta) + centre_x,
// y = r*sin(theta) + centre_y, Q16.16 with saturation.
//
// Usage:
//   req carries one request: func 0 gives a point at the supplied Q3.20
//   angle, func 1 gives the next point of the configured sweep (last marks
//   its final point, after which the sweep restarts at angle 0).
//   rsp returns one point per request, in order.
//   cfg_we/cfg_index/cfg_data write the registers; write only while idle.
// Timing:
//   One request at a time: a new request is taken only once the previous
//   point has gone to the output register. Each point takes two passes
//   of the shared iterative CORDIC.
//   The finished point sits in an output register, so the next request is
//   taken while it waits. If the receiver stalls, the following point waits
//   in the datapath until the register frees.
// Reset: rst is synchronous; registers return to their defaults and the
//   sweep to angle 0, index 0.
// ----------------------------------------------------------------------------
module sinusoidal_polar_curve_points #(
  parameter int CORDIC_ITERATIONS = spcp_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [spcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spcp_pkg::CFG_DATA_W-1:0] cfg_data,
  spcp_req_if.sink                        req,
  spcp_rsp_if.source                      rsp
);
  import spcp_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  spcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .op        (op)
  );

  spcp_datapath #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_func  (req.func),
    .req_angle (req.angle),
    .op        (op),
    .status    (status),
    .rsp_x     (rsp.x),
    .rsp_y     (rsp.y),
    .rsp_last  (rsp.last)
  );

endmodule
